FILE: design/nbd_pkg.sv
// Shared constants and types for the nearest-beacon distance block.
`default_nettype none

package nbd_pkg;

  localparam int unsigned MAX_BEACONS_DEF   = 64;
  localparam int unsigned FRACTION_BITS_DEF = 4;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned DIST_W  = 15;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef logic [OP_W-1:0] opcode_t;

  localparam opcode_t OP_CLEAR  = 2'd0;
  localparam opcode_t OP_APPEND = 2'd1;
  localparam opcode_t OP_QUERY  = 2'd2;

  // Query token that walks the cell row.
  typedef struct packed {
    logic             vld;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
  } qry_tok_t;

endpackage

`default_nettype wire

FILE: design/nbd_if.sv
// Valid/ready channel interfaces for commands and distance results.
`default_nettype none

interface nbd_in_if;
  logic                        valid;
  logic                        ready;
  logic [nbd_pkg::OP_W-1:0]    opcode;
  logic [nbd_pkg::POS_W-1:0]   pos_x;
  logic [nbd_pkg::POS_W-1:0]   pos_y;

  modport source (output valid, opcode, pos_x, pos_y, input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, output ready);
endinterface

interface nbd_out_if;
  logic                         valid;
  logic                         ready;
  logic [nbd_pkg::DIST_W-1:0]   distance;
  logic                         no_beacon;

  modport source (output valid, distance, no_beacon, input ready);
  modport sink   (input valid, distance, no_beacon, output ready);
endinterface

`default_nettype wire

FILE: design/nbd_cell.sv
// One beacon cell: holds a beacon, scores the passing query and keeps the running minimum.
`default_nettype none

module nbd_cell #(
  parameter int unsigned IDX           = 0,
  parameter int unsigned CNT_W         = 7,
  parameter int unsigned FRACTION_BITS = 4,
  parameter int unsigned DIFF_W        = 14,
  parameter int unsigned SQ_W          = 29
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire logic [CNT_W-1:0]             count,
  input  wire logic [nbd_pkg::COORD_W-1:0]  wr_x,
  input  wire logic [nbd_pkg::COORD_W-1:0]  wr_y,
  input  wire nbd_pkg::qry_tok_t            tok_in,
  input  wire logic                         have_in,
  input  wire logic [SQ_W-1:0]              best_in,
  input  wire logic                         cand_v_in,
  input  wire logic [SQ_W-1:0]              cand_in,
  output nbd_pkg::qry_tok_t                 tok_out,
  output logic                              have_out,
  output logic [SQ_W-1:0]                   best_out,
  output logic                              cand_v_out,
  output logic [SQ_W-1:0]                   cand_out
);
  import nbd_pkg::*;

  logic [COORD_W-1:0]  bx_r, by_r;
  logic                active;
  logic [DIFF_W-1:0]   bxs, bys, pxe, pye, dx, dy;
  logic [2*DIFF_W-1:0] dx_sq, dy_sq;
  logic [SQ_W-1:0]     sq;
  logic                take_cand;

  logic                tok_vld_r;
  logic [POS_W-1:0]    tok_px_r, tok_py_r;
  logic                have_r, cand_v_r;
  logic [SQ_W-1:0]     best_r, cand_r;

  assign active = (CNT_W'(IDX) < count);

  always_ff @(posedge clk) begin
    if (wr_en && count == CNT_W'(IDX)) begin
      bx_r <= wr_x;
      by_r <= wr_y;
    end
  end

  // Distance of this cell's beacon to the passing query.
  always_comb begin
    bxs   = DIFF_W'(bx_r) << FRACTION_BITS;
    bys   = DIFF_W'(by_r) << FRACTION_BITS;
    pxe   = DIFF_W'(tok_in.px);
    pye   = DIFF_W'(tok_in.py);
    dx    = (bxs >= pxe) ? (bxs - pxe) : (pxe - bxs);
    dy    = (bys >= pye) ? (bys - pye) : (pye - bys);
    dx_sq = (2*DIFF_W)'(dx) * (2*DIFF_W)'(dx);
    dy_sq = (2*DIFF_W)'(dy) * (2*DIFF_W)'(dy);
    sq    = SQ_W'(dx_sq) + SQ_W'(dy_sq);
  end

  // Fold the upstream candidate into the running minimum.
  assign take_cand = cand_v_in && (!have_in || cand_in < best_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
      have_r    <= 1'b0;
      cand_v_r  <= 1'b0;
    end else begin
      tok_vld_r <= tok_in.vld;
      have_r    <= have_in | cand_v_in;
      cand_v_r  <= tok_in.vld & active;
    end
  end

  always_ff @(posedge clk) begin
    tok_px_r <= tok_in.px;
    tok_py_r <= tok_in.py;
    best_r   <= take_cand ? cand_in : best_in;
    cand_r   <= sq;
  end

  assign tok_out    = '{vld: tok_vld_r, px: tok_px_r, py: tok_py_r};
  assign have_out   = have_r;
  assign best_out   = best_r;
  assign cand_v_out = cand_v_r;
  assign cand_out   = cand_r;

endmodule

`default_nettype wire

FILE: design/nbd_isqrt.sv
// Iterative floor square root, one result bit per cycle.
`default_nettype none

module nbd_isqrt #(
  parameter int unsigned VAL_W = 30
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] value,
  output logic                  done,
  output logic [VAL_W-1:0]      root
);
  logic [VAL_W-1:0] rem_r, rem_nxt;
  logic [VAL_W-1:0] root_r, root_nxt;
  logic [VAL_W-1:0] bit_r, bit_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [VAL_W-1:0] trial;

  assign trial = root_r + bit_r;

  always_comb begin
    rem_nxt  = rem_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = value;
      root_nxt = '0;
      bit_nxt  = VAL_W'(1) << (VAL_W - 2);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt  = rem_r - trial;
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

FILE: design/nearest_beacon_distance_core.sv
// Top level of the nearest-beacon distance block: command decode, cell row and root unit.
//
// Usage:
//   in_ch carries commands (opcode, pos_x, pos_y); out_ch carries one result
//   (distance, no_beacon) for each query. Clear and append produce no result;
//   opcode 3 is dropped. Coordinates are unsigned with FRACTION_BITS fraction bits.
//   Clear and append leave the block idle, ready for the next command. A query
//   enters a row of MAX_BEACONS cells, one cell per cycle, then a bit-serial
//   square root unit; the result is loaded into the output register once the
//   root is done. Commands are taken one at a time: the input is held off until
//   the result is loaded. A finished result sits in the output register; the
//   block takes new commands while it waits there. A query that finishes while
//   the previous result is still unclaimed holds in the root stage until the
//   receiver takes it.
//   Reset (rst_n low, synchronous) empties the beacon table and drops any
//   query in flight; beacon cells hold no reset value and are never read
//   beyond the current beacon count.
`default_nettype none

module nearest_beacon_distance_core #(
  parameter int unsigned MAX_BEACONS   = nbd_pkg::MAX_BEACONS_DEF,
  parameter int unsigned FRACTION_BITS = nbd_pkg::FRACTION_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  nbd_in_if.sink     in_ch,
  nbd_out_if.source  out_ch
);
  import nbd_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_BEACONS + 1);
  localparam int unsigned DIFF_W = (COORD_W + FRACTION_BITS > POS_W) ?
                                   (COORD_W + FRACTION_BITS) : POS_W;
  localparam int unsigned SQ_W   = 2 * DIFF_W + 1;
  localparam int unsigned RAD_W  = 2 * ((SQ_W + 1) / 2);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             in_xfer, out_xfer, wr_en, launch;
  logic [COORD_W-1:0] wr_x, wr_y;

  qry_tok_t         tok   [MAX_BEACONS+1];
  logic             have  [MAX_BEACONS+1];
  logic [SQ_W-1:0]  best  [MAX_BEACONS+1];
  logic             cand_v[MAX_BEACONS+1];
  logic [SQ_W-1:0]  cand  [MAX_BEACONS+1];

  logic             tail_have, tail_take;
  logic [SQ_W-1:0]  tail_best;
  logic             have_r, have_nxt;
  logic             sq_start, sq_done;
  logic [RAD_W-1:0] sq_root;
  logic             out_free, finish;

  logic             out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] dist_r, nob_dist;
  logic             nob_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;
  assign wr_en       = in_xfer && in_ch.opcode == OP_APPEND &&
                       count_r < CNT_W'(MAX_BEACONS);
  assign launch      = in_xfer && in_ch.opcode == OP_QUERY;
  assign wr_x        = COORD_W'(in_ch.pos_x >> FRACTION_BITS);
  assign wr_y        = COORD_W'(in_ch.pos_y >> FRACTION_BITS);

  // Head of the row: a fresh token with no minimum yet.
  assign tok[0]     = '{vld: launch, px: in_ch.pos_x, py: in_ch.pos_y};
  assign have[0]    = 1'b0;
  assign best[0]    = '0;
  assign cand_v[0]  = 1'b0;
  assign cand[0]    = '0;

  for (genvar i = 0; i < MAX_BEACONS; i++) begin : g_cell
    nbd_cell #(
      .IDX           (i),
      .CNT_W         (CNT_W),
      .FRACTION_BITS (FRACTION_BITS),
      .DIFF_W        (DIFF_W),
      .SQ_W          (SQ_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .wr_en      (wr_en),
      .count      (count_r),
      .wr_x       (wr_x),
      .wr_y       (wr_y),
      .tok_in     (tok[i]),
      .have_in    (have[i]),
      .best_in    (best[i]),
      .cand_v_in  (cand_v[i]),
      .cand_in    (cand[i]),
      .tok_out    (tok[i+1]),
      .have_out   (have[i+1]),
      .best_out   (best[i+1]),
      .cand_v_out (cand_v[i+1]),
      .cand_out   (cand[i+1])
    );
  end

  // Fold the last cell's candidate in as the token leaves the row.
  assign tail_take = cand_v[MAX_BEACONS] &&
                     (!have[MAX_BEACONS] || cand[MAX_BEACONS] < best[MAX_BEACONS]);
  assign tail_best = tail_take ? cand[MAX_BEACONS] : best[MAX_BEACONS];
  assign tail_have = have[MAX_BEACONS] | cand_v[MAX_BEACONS];
  assign sq_start  = (state_r == ST_SCAN) && tok[MAX_BEACONS].vld;

  nbd_isqrt #(
    .VAL_W (RAD_W)
  ) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (tail_have ? RAD_W'(tail_best) : '0),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign finish   = (state_r == ST_ROOT) && sq_done && out_free;
  assign nob_dist = (|sq_root[RAD_W-1:DIST_W]) ? DIST_MAX : sq_root[DIST_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    have_nxt      = have_r;
    out_valid_nxt = out_valid_r;
    if (out_xfer) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_ch.opcode)
            OP_CLEAR:  count_nxt = '0;
            OP_APPEND: if (wr_en) count_nxt = count_r + CNT_W'(1);
            OP_QUERY:  state_nxt = ST_SCAN;
            default:   ;
          endcase
        end
      end
      ST_SCAN: begin
        if (sq_start) begin
          have_nxt  = tail_have;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (finish) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      dist_r <= have_r ? nob_dist : '0;
      nob_r  <= !have_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.distance  = dist_r;
  assign out_ch.no_beacon = nob_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BEACONS))
    else $error("beacon count beyond table size");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok[MAX_BEACONS].vld |-> state_r == ST_SCAN)
    else $error("query token left the row outside of a scan");

  a_result_from_root: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_ROOT)
    else $error("result loaded without a finished root");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    launch |=> !in_ch.ready)
    else $error("command taken while a query is in flight");

endmodule

`default_nettype wire

FILE: dv/nearest_beacon_distance_core_tb.sv
// Self-checking testbench for the nearest-beacon distance core: random commands, distance check.
`default_nettype none

module nearest_beacon_distance_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nbd_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_BEACONS_DEF;
  localparam int unsigned FRAC        = FRACTION_BITS_DEF;
  localparam int unsigned ITEM_TARGET = 1100;
  localparam int unsigned QUIET_TAIL  = 120;
  localparam int unsigned DRAIN_WAIT  = 120;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam opcode_t OP_NONE = 2'd3;

  typedef struct packed {
    opcode_t          opcode;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } beacon_cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              no_beacon;
  } distance_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nbd_in_if  in_if ();
  nbd_out_if out_if ();

  nearest_beacon_distance_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  beacon_cmd_t      pending_cmds[$];
  distance_result_t expected_distances[$];

  // Shadow beacon table.
  logic [COORD_W-1:0] shadow_x [TABLE_DEPTH];
  logic [COORD_W-1:0] shadow_y [TABLE_DEPTH];
  int unsigned        shadow_count = 0;

  int unsigned item_count    = 0;
  int unsigned checked_count = 0;
  int unsigned dropped_appends = 0;
  int unsigned empty_queries = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_gap      = 0;
  int unsigned recv_stall    = 0;
  logic [POS_W-1:0] last_x = '0;
  logic [POS_W-1:0] last_y = '0;

  function automatic logic [DIST_W-1:0] floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      cand = root | (longint'(1) << b);
      if (cand * cand <= v)
        root = cand;
    end
    if (root > DIST_MAX)
      root = DIST_MAX;
    return root[DIST_W-1:0];
  endfunction

  function automatic longint unsigned sq_gap(longint unsigned a, longint unsigned b);
    longint unsigned d;
    d = (a >= b) ? a - b : b - a;
    return d * d;
  endfunction

  // Advance the shadow table by one accepted command; queue the distance a query owes.
  function automatic void apply_command(beacon_cmd_t c);
    distance_result_t r;
    longint unsigned  best;
    longint unsigned  sq;
    best = 0;
    case (c.opcode)
      OP_CLEAR: shadow_count = 0;
      OP_APPEND: begin
        if (shadow_count < TABLE_DEPTH) begin
          shadow_x[shadow_count] = COORD_W'(c.pos_x >> FRAC);
          shadow_y[shadow_count] = COORD_W'(c.pos_y >> FRAC);
          shadow_count++;
        end else begin
          dropped_appends++;
        end
      end
      OP_QUERY: begin
        if (shadow_count == 0) begin
          r.distance  = '0;
          r.no_beacon = 1'b1;
          empty_queries++;
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            sq = sq_gap(longint'(shadow_x[i]) << FRAC, c.pos_x)
               + sq_gap(longint'(shadow_y[i]) << FRAC, c.pos_y);
            if (i == 0 || sq < best)
              best = sq;
          end
          r.distance  = floor_root(best);
          r.no_beacon = 1'b0;
        end
        expected_distances = {expected_distances, r};
      end
      default: ;
    endcase
  endfunction

  task automatic push_cmd(opcode_t op, logic [POS_W-1:0] x, logic [POS_W-1:0] y);
    beacon_cmd_t c;
    c.opcode = op;
    c.pos_x  = x;
    c.pos_y  = y;
    pending_cmds = {pending_cmds, c};
    if (op != OP_NONE)
      item_count++;
    if (op == OP_APPEND) begin
      last_x = x;
      last_y = y;
    end
  endtask

  function automatic logic [POS_W-1:0] nudge(logic [POS_W-1:0] p);
    int unsigned v;
    v = p + $urandom_range(0, 40);
    return (v > POS_MAX) ? POS_MAX : POS_W'(v);
  endfunction

  // Clear, overfill the table, then query it.
  task automatic fill_table();
    push_cmd(OP_CLEAR, POS_W'($urandom), POS_W'($urandom));
    repeat (TABLE_DEPTH + $urandom_range(1, 4))
      push_cmd(OP_APPEND, POS_W'($urandom), POS_W'($urandom));
    push_cmd(OP_QUERY, nudge(last_x), nudge(last_y));
    repeat (2)
      push_cmd(OP_QUERY, POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic build_stimulus();
    int unsigned r;
    // Directed: empty table, extremes, fraction bits, ignored opcode.
    push_cmd(OP_QUERY, '0, '0);
    push_cmd(OP_QUERY, POS_MAX, POS_MAX);
    push_cmd(OP_NONE, '0, '0);
    push_cmd(OP_CLEAR, '0, '0);
    push_cmd(OP_APPEND, POS_MAX, POS_MAX);
    push_cmd(OP_QUERY, POS_MAX, POS_MAX);
    push_cmd(OP_QUERY, '0, '0);
    push_cmd(OP_APPEND, '0, '0);
    push_cmd(OP_QUERY, '0, POS_MAX);
    push_cmd(OP_QUERY, POS_MAX, '0);
    push_cmd(OP_APPEND, 14'h2AAA, 14'h1555);
    push_cmd(OP_QUERY, 14'h2AA0, 14'h1550);
    push_cmd(OP_QUERY, 14'h1555, 14'h2AAA);
    push_cmd(OP_NONE, POS_MAX, POS_MAX);
    push_cmd(OP_CLEAR, POS_MAX, POS_MAX);
    push_cmd(OP_QUERY, 14'h0123, 14'h3210);
    push_cmd(OP_APPEND, 14'd8, 14'd8);
    push_cmd(OP_QUERY, 14'd8, 14'd8);
    push_cmd(OP_QUERY, '0, '0);
    fill_table();

    while (item_count < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        fill_table();
      end else begin
        if (r < 30)
          push_cmd(OP_CLEAR, POS_W'($urandom), POS_W'($urandom));
        repeat ($urandom_range(0, 6))
          push_cmd(OP_APPEND, POS_W'($urandom), POS_W'($urandom));
        repeat ($urandom_range(1, 4)) begin
          r = $urandom_range(0, 99);
          if (r < 5)
            push_cmd(OP_NONE, POS_W'($urandom), POS_W'($urandom));
          else if (r < 45)
            push_cmd(OP_QUERY, nudge(last_x), nudge(last_y));
          else
            push_cmd(OP_QUERY, POS_W'($urandom), POS_W'($urandom));
        end
      end
    end
  endtask

  // Command driver
  always @(posedge clk) begin
    beacon_cmd_t c;
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      in_if.opcode <= OP_CLEAR;
      in_if.pos_x  <= '0;
      in_if.pos_y  <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap != 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        in_if.valid  <= 1'b1;
        in_if.opcode <= c.opcode;
        in_if.pos_x  <= c.pos_x;
        in_if.pos_y  <= c.pos_y;
        if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
          send_gap = $urandom_range(1, 12);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (recv_stall != 0) begin
      recv_stall--;
      out_if.ready <= 1'b0;
    end else if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
      recv_stall = $urandom_range(1, 12) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Monitor: predict on each command transfer, check each result transfer.
  always @(posedge clk) begin
    beacon_cmd_t      c;
    distance_result_t exp_r;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        c.opcode = in_if.opcode;
        c.pos_x  = in_if.pos_x;
        c.pos_y  = in_if.pos_y;
        apply_command(c);
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_distances.size() == 0) begin
          $error("unexpected result: distance=%0d no_beacon=%0b",
                 out_if.distance, out_if.no_beacon);
          error_count++;
        end else begin
          exp_r = expected_distances.pop_front();
          checked_count++;
          if (out_if.distance !== exp_r.distance) begin
            $error("distance: expected %0d, got %0d", exp_r.distance, out_if.distance);
            error_count++;
          end
          if (out_if.no_beacon !== exp_r.no_beacon) begin
            $error("no_beacon: expected %0b, got %0b", exp_r.no_beacon, out_if.no_beacon);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_cmds.size() != 0 || in_if.valid)
      @(posedge clk);
    while (expected_distances.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("sent %0d commands, checked %0d distances (%0d on an empty table)",
             item_count, checked_count, empty_queries);
    $display("appends dropped on a full table: %0d, errors: %0d",
             dropped_appends, error_count);
    if (error_count == 0 && expected_distances.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
